### rtl/smbp_pkg.sv
`default_nettype none
package smbp_pkg;

    // Default geometry of the splat store.
    localparam int CELL_VERTICES_DEF = 64;
    localparam int SPLAT_LAYERS_DEF  = 4;

    // Register indexes on the configuration port.
    localparam logic [2:0] REG_BRUSH_X        = 3'd0;
    localparam logic [2:0] REG_BRUSH_Z        = 3'd1;
    localparam logic [2:0] REG_BRUSH_RADIUS   = 3'd2;
    localparam logic [2:0] REG_BRUSH_STRENGTH = 3'd3;
    localparam logic [2:0] REG_PAINT_LAYER    = 3'd4;
    localparam logic [2:0] REG_ERASE_MODE     = 3'd5;
    localparam logic [2:0] REG_SCALE_X        = 3'd6;
    localparam logic [2:0] REG_SCALE_Z        = 3'd7;

    // Register reset values.
    localparam logic [19:0] RADIUS_RST   = 20'd256;
    localparam logic [15:0] STRENGTH_RST = 16'd4096;
    localparam logic [11:0] SCALE_RST    = 12'd256;

    // Smoothstep constant 3.0 in Q.16.
    localparam logic [17:0] THREE_Q16 = 18'd196608;

    // Pipeline lengths of the square root and the falloff divider.
    localparam int SQRT_STAGES = 21;
    localparam int DIV_STAGES  = 17;

endpackage
`default_nettype wire

### rtl/smbp_ram.sv
`default_nettype none
module smbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16384
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // A read and a write of the same entry in one cycle return the old data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

### rtl/splat_map_brush_paint_unit.sv
`default_nettype none
// Radial smoothstep brush that paints one layer of a terrain cell's splat map.
// Input stream (s_*): one vertex per transfer; s_tdata carries the vertex
// column and row, s_tlast marks the final vertex of a stamp pass.
// Output stream (m_*): one result per vertex, in order; m_tdata carries the
// new channel value, the changed flag and the inside flag, m_tlast copies
// s_tlast.
// The brush is to be set up through the APB-style port while the stream is
// idle; the block itself does not enforce this. A vertex goes through 47
// pipeline stages (distance, a 21-stage square root, a 17-stage falloff
// divider, the smoothstep and paint amount, and a read-modify-write of the
// splat memory). One vertex is taken every cycle unless the output stalls;
// the single write port and registered read of the splat memory set that
// rate; a write forward covers back-to-back vertices that hit the same entry.
// After reset the splat memory is swept to zero, one entry a cycle, over all
// CELL_VERTICES*CELL_VERTICES*SPLAT_LAYERS entries (16384 by default);
// s_tready stays low until then, while register writes are taken as ever.
// When the receiver stalls, the whole pipeline holds and s_tready falls; the
// output register keeps its result until it is taken.
module splat_map_brush_paint_unit
    import smbp_pkg::*;
#(
    parameter int CELL_VERTICES = CELL_VERTICES_DEF,
    parameter int SPLAT_LAYERS  = SPLAT_LAYERS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Configuration port.
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // Vertex stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [5:0] vertex_x, [11:6] vertex_z, rest zero
    input  wire logic        s_tlast,   // last_vertex
    // Result stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] channel_value, [8] changed,
                                        // [9] inside_brush, rest zero
    output logic             m_tlast    // last_result
);

    localparam int DEPTH  = CELL_VERTICES * CELL_VERTICES * SPLAT_LAYERS;
    localparam int ADDR_W = $clog2(DEPTH);
    // Pipeline stage numbers.
    localparam int ST_ROOT = 3 + SQRT_STAGES;       // root is ready
    localparam int ST_CMP  = ST_ROOT + 1;           // inside test, difference
    localparam int ST_FQ   = ST_CMP + DIV_STAGES;   // falloff is ready
    localparam int ST_A    = ST_FQ + 4;             // paint amount, memory read
    localparam int ST_B    = ST_A + 1;              // modify and write back

    typedef struct packed {
        logic              valid;
        logic              last;
        logic              in_cell;
        logic [ADDR_W-1:0] addr;
    } tag_t;

    // ---------------- configuration registers ----------------
    logic [19:0] brush_x_reg, brush_z_reg, brush_radius_reg;
    logic [15:0] brush_strength_reg;
    logic [1:0]  paint_layer_reg;
    logic        erase_mode_reg;
    logic [11:0] scale_x_reg, scale_z_reg;
    logic        cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brush_x_reg        <= '0;
            brush_z_reg        <= '0;
            brush_radius_reg   <= RADIUS_RST;
            brush_strength_reg <= STRENGTH_RST;
            paint_layer_reg    <= '0;
            erase_mode_reg     <= 1'b0;
            scale_x_reg        <= SCALE_RST;
            scale_z_reg        <= SCALE_RST;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                REG_BRUSH_X:        brush_x_reg        <= pwdata[19:0];
                REG_BRUSH_Z:        brush_z_reg        <= pwdata[19:0];
                REG_BRUSH_RADIUS:   brush_radius_reg   <= pwdata[19:0];
                REG_BRUSH_STRENGTH: brush_strength_reg <= pwdata[15:0];
                REG_PAINT_LAYER:    paint_layer_reg    <= pwdata[1:0];
                REG_ERASE_MODE:     erase_mode_reg     <= pwdata[0];
                REG_SCALE_X:        scale_x_reg        <= pwdata[11:0];
                REG_SCALE_Z:        scale_z_reg        <= pwdata[11:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_BRUSH_X:        prdata = {12'd0, brush_x_reg};
            REG_BRUSH_Z:        prdata = {12'd0, brush_z_reg};
            REG_BRUSH_RADIUS:   prdata = {12'd0, brush_radius_reg};
            REG_BRUSH_STRENGTH: prdata = {16'd0, brush_strength_reg};
            REG_PAINT_LAYER:    prdata = {30'd0, paint_layer_reg};
            REG_ERASE_MODE:     prdata = {31'd0, erase_mode_reg};
            REG_SCALE_X:        prdata = {20'd0, scale_x_reg};
            REG_SCALE_Z:        prdata = {20'd0, scale_z_reg};
            default:            prdata = '0;
        endcase
    end

    // ---------------- clearing sweep and flow control ----------------
    logic              clearing_reg;
    logic [ADDR_W-1:0] clr_addr_reg;
    logic              en;
    logic              in_xfer;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (clearing_reg)
        begin
            clr_addr_reg <= clr_addr_reg + 1'b1;
            if (clr_addr_reg == ADDR_W'(DEPTH - 1))
            begin
                clearing_reg <= 1'b0;
            end
        end
    end

    // The whole pipeline advances together whenever the output can move.
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en && !clearing_reg;
    assign in_xfer  = s_tvalid && s_tready;

    // ---------------- stage 1: offsets and store address ----------------
    logic [5:0]  vx, vz;
    logic [2:0]  layer;
    logic [17:0] px, pz;
    logic signed [20:0] dx, dz;
    tag_t        tag_in;

    assign vx = s_tdata[5:0];
    assign vz = s_tdata[11:6];
    // Layer numbers beyond the store are clamped to the top layer.
    assign layer = ({1'b0, paint_layer_reg} > 3'(SPLAT_LAYERS - 1)) ?
                   3'(SPLAT_LAYERS - 1) : {1'b0, paint_layer_reg};
    assign px = 18'(vx) * 18'(scale_x_reg);
    assign pz = 18'(vz) * 18'(scale_z_reg);
    assign dx = $signed({3'd0, px}) - 21'(signed'(brush_x_reg));
    assign dz = $signed({3'd0, pz}) - 21'(signed'(brush_z_reg));

    always_comb
    begin
        tag_in.valid   = in_xfer;
        tag_in.last    = s_tlast;
        tag_in.in_cell = (32'(vx) < CELL_VERTICES) && (32'(vz) < CELL_VERTICES);
        tag_in.addr    = ADDR_W'((32'(vz) * CELL_VERTICES + 32'(vx)) * SPLAT_LAYERS
                                 + 32'(layer));
    end

    tag_t tag_reg [1:ST_B];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 1; i <= ST_B; i++)
            begin
                tag_reg[i] <= '0;
            end
        end
        else if (en)
        begin
            tag_reg[1] <= tag_in;
            for (int i = 2; i <= ST_B; i++)
            begin
                tag_reg[i] <= tag_reg[i-1];
            end
        end
    end

    logic [19:0] adx_reg, adz_reg;
    logic [39:0] sqx_reg, sqz_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            adx_reg <= dx[20] ? 20'(-dx) : dx[19:0];
            adz_reg <= dz[20] ? 20'(-dz) : dz[19:0];
            sqx_reg <= 40'(adx_reg) * 40'(adx_reg);
            sqz_reg <= 40'(adz_reg) * 40'(adz_reg);
        end
    end

    // ---------------- floor square root, one root bit a stage ----------------
    logic [41:0] sq_rad_reg  [0:SQRT_STAGES];
    logic [23:0] sq_rem_reg  [0:SQRT_STAGES];
    logic [20:0] sq_root_reg [0:SQRT_STAGES];
    logic [41:0] sq_rad_next [SQRT_STAGES];
    logic [23:0] sq_rem_next [SQRT_STAGES];
    logic [20:0] sq_root_next[SQRT_STAGES];

    for (genvar k = 0; k < SQRT_STAGES; k++)
    begin : g_sqrt
        logic [23:0] rem_sh, trial;
        assign rem_sh = {sq_rem_reg[k][21:0], sq_rad_reg[k][41:40]};
        assign trial  = {1'b0, sq_root_reg[k], 2'b01};
        always_comb
        begin
            sq_rad_next[k] = {sq_rad_reg[k][39:0], 2'b00};
            if (rem_sh >= trial)
            begin
                sq_rem_next[k]  = rem_sh - trial;
                sq_root_next[k] = {sq_root_reg[k][19:0], 1'b1};
            end
            else
            begin
                sq_rem_next[k]  = rem_sh;
                sq_root_next[k] = {sq_root_reg[k][19:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_rad_reg[0]  <= {1'b0, 41'(sqx_reg) + 41'(sqz_reg)};
            sq_rem_reg[0]  <= '0;
            sq_root_reg[0] <= '0;
            for (int k = 0; k < SQRT_STAGES; k++)
            begin
                sq_rad_reg[k+1]  <= sq_rad_next[k];
                sq_rem_reg[k+1]  <= sq_rem_next[k];
                sq_root_reg[k+1] <= sq_root_next[k];
            end
        end
    end

    // ---------------- inside test and falloff divider ----------------
    logic [20:0] root_dist;
    logic        in_radius;
    logic [19:0] diff;

    assign root_dist = sq_root_reg[SQRT_STAGES];
    assign in_radius = (brush_radius_reg != '0) && (root_dist <= {1'b0, brush_radius_reg});
    assign diff      = in_radius ? (brush_radius_reg - root_dist[19:0]) : '0;

    // (radius - dist) * 2^16 / radius, one quotient bit a stage; only the
    // lowest bit of the difference is still to be shifted in after the start.
    logic [19:0] dv_rem_reg [0:DIV_STAGES];
    logic [16:0] dv_q_reg   [0:DIV_STAGES];
    logic        dv_b_reg   [0:DIV_STAGES];
    logic [19:0] dv_rem_next[DIV_STAGES];
    logic [16:0] dv_q_next  [DIV_STAGES];

    for (genvar j = 0; j < DIV_STAGES; j++)
    begin : g_div
        logic [20:0] rem_sh;
        assign rem_sh = {dv_rem_reg[j], (j == 0) ? dv_b_reg[j] : 1'b0};
        always_comb
        begin
            if (rem_sh >= {1'b0, brush_radius_reg})
            begin
                dv_rem_next[j] = 20'(rem_sh - {1'b0, brush_radius_reg});
                dv_q_next[j]   = {dv_q_reg[j][15:0], 1'b1};
            end
            else
            begin
                dv_rem_next[j] = rem_sh[19:0];
                dv_q_next[j]   = {dv_q_reg[j][15:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_rem_reg[0] <= {1'b0, diff[19:1]};
            dv_b_reg[0]   <= diff[0];
            dv_q_reg[0]   <= '0;
            for (int j = 0; j < DIV_STAGES; j++)
            begin
                dv_rem_reg[j+1] <= dv_rem_next[j];
                dv_q_reg[j+1]   <= dv_q_next[j];
                dv_b_reg[j+1]   <= 1'b0;
            end
        end
    end

    logic inside_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            inside_reg <= in_radius;
        end
    end

    // ---------------- smoothstep weight and paint amount ----------------
    logic [16:0] f_reg;
    logic [33:0] ff_reg;
    logic [51:0] wprod;
    logic [16:0] w_reg;
    logic signed [34:0] sprod_reg;
    logic [28:0] clamped;
    logic [36:0] amt_wide;
    logic [7:0]  amt_reg, amt_b_reg;
    logic        ins_d_reg [ST_CMP+1:ST_B];

    assign wprod = 52'(ff_reg) * 52'(THREE_Q16 - {f_reg, 1'b0});
    always_comb
    begin
        if (sprod_reg <= 35'sd0)
        begin
            clamped = '0;
        end
        else if (sprod_reg > 35'sd268435456)
        begin
            clamped = 29'd268435456;
        end
        else
        begin
            clamped = sprod_reg[28:0];
        end
    end
    assign amt_wide = {clamped, 8'd0} - 37'(clamped);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_reg     <= dv_q_reg[DIV_STAGES];
            ff_reg    <= 34'(dv_q_reg[DIV_STAGES]) * 34'(dv_q_reg[DIV_STAGES]);
            w_reg     <= wprod[48:32];
            sprod_reg <= 35'(signed'(brush_strength_reg)) * $signed({18'd0, w_reg});
            amt_reg   <= (ins_d_reg[ST_A-1] && tag_reg[ST_A-1].in_cell) ?
                         amt_wide[35:28] : 8'd0;
            amt_b_reg <= amt_reg;
            ins_d_reg[ST_CMP+1] <= inside_reg;
            for (int i = ST_CMP + 2; i <= ST_B; i++)
            begin
                ins_d_reg[i] <= ins_d_reg[i-1];
            end
        end
    end

    // ---------------- read-modify-write of the splat memory ----------------
    logic [7:0]        rdata, old_val, new_val;
    logic              lw_valid_reg;
    logic [ADDR_W-1:0] lw_addr_reg;
    logic [7:0]        lw_data_reg;
    logic              wr_item;
    logic [8:0]        sum9;
    tag_t              tb;

    assign tb = tag_reg[ST_B];
    // The write of the vertex just ahead lands in the same cycle as this
    // vertex's read, so its data is taken from the last-write register.
    assign old_val = (lw_valid_reg && lw_addr_reg == tb.addr) ? lw_data_reg : rdata;
    assign sum9    = {1'b0, old_val} + {1'b0, amt_b_reg};
    always_comb
    begin
        if (erase_mode_reg)
        begin
            new_val = (old_val > amt_b_reg) ? (old_val - amt_b_reg) : 8'd0;
        end
        else
        begin
            new_val = sum9[8] ? 8'd255 : sum9[7:0];
        end
    end
    assign wr_item = tb.valid && tb.in_cell && (amt_b_reg != 8'd0);

    smbp_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (clearing_reg || (en && wr_item)),
        .waddr (clearing_reg ? clr_addr_reg : tb.addr),
        .wdata (clearing_reg ? 8'd0 : new_val),
        .re    (en),
        .raddr (tag_reg[ST_A].addr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lw_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            lw_valid_reg <= wr_item;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lw_addr_reg <= tb.addr;
            lw_data_reg <= new_val;
        end
    end

    // ---------------- output register ----------------
    logic [7:0] res_val;
    logic       res_chg, res_ins;

    assign res_val = !tb.in_cell ? 8'd0 : (wr_item ? new_val : old_val);
    assign res_chg = wr_item && (new_val != old_val);
    assign res_ins = tb.in_cell && ins_d_reg[ST_B];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid <= 1'b0;
        end
        else if (en)
        begin
            m_tvalid <= tb.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en && tb.valid)
        begin
            m_tdata <= {6'd0, res_ins, res_chg, res_val};
            m_tlast <= tb.last;
        end
    end

endmodule
`default_nettype wire
